// ----- hw/rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Shared helpers for the concurrent assertions of the tokenizer checker.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is held.
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/stt_pkg.sv -----
// ============================================================================
// Tokenizer package
// Token kinds, character codes, result types and character class helpers.
// ============================================================================
package stt_pkg;

    // Token kinds as delivered on the result channel.
    localparam logic [4:0] KIND_IDENT      = 5'd0;
    localparam logic [4:0] KIND_KW_INT     = 5'd1;
    localparam logic [4:0] KIND_KW_BOOL    = 5'd2;
    localparam logic [4:0] KIND_KW_DSPL    = 5'd3;
    localparam logic [4:0] KIND_KW_STRING  = 5'd4;
    localparam logic [4:0] KIND_KW_DECIMAL = 5'd5;
    localparam logic [4:0] KIND_INTEGER    = 5'd6;
    localparam logic [4:0] KIND_DECIMAL    = 5'd7;
    localparam logic [4:0] KIND_BOOLEAN    = 5'd8;
    localparam logic [4:0] KIND_STRING     = 5'd9;
    localparam logic [4:0] KIND_PLUS       = 5'd10;
    localparam logic [4:0] KIND_MINUS      = 5'd11;
    localparam logic [4:0] KIND_STAR       = 5'd12;
    localparam logic [4:0] KIND_SLASH      = 5'd13;
    localparam logic [4:0] KIND_EQUAL      = 5'd14;
    localparam logic [4:0] KIND_COLON      = 5'd15;
    localparam logic [4:0] KIND_SEMI       = 5'd16;
    localparam logic [4:0] KIND_COMMA      = 5'd17;
    localparam logic [4:0] KIND_LPAREN     = 5'd18;
    localparam logic [4:0] KIND_RPAREN     = 5'd19;
    localparam logic [4:0] KIND_LBRACE     = 5'd20;
    localparam logic [4:0] KIND_RBRACE     = 5'd21;
    localparam logic [4:0] KIND_UNKNOWN    = 5'd22;

    // Character codes with a special meaning to the scanner.
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // Reserved words, one byte per lane, right aligned.
    localparam logic [55:0] WORD_INT     = 56'h696E74;
    localparam logic [55:0] WORD_BOOL    = 56'h626F6F6C;
    localparam logic [55:0] WORD_DSPL    = 56'h6473706C;
    localparam logic [55:0] WORD_STRING  = 56'h737472696E67;
    localparam logic [55:0] WORD_DECIMAL = 56'h646563696D616C;
    localparam logic [55:0] WORD_TRUE    = 56'h74727565;
    localparam logic [55:0] WORD_FALSE   = 56'h66616C7365;

    // Depth of the result queue; it must hold two results beyond two waiting.
    localparam int unsigned QUEUE_DEPTH = 4;

    // One result item.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] lexeme_length;
        logic        run_last;
    } stt_res_t;

    // Results produced by one scanned byte, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        stt_res_t   res0;
        stt_res_t   res1;
    } stt_push_t;

    // Outcome of the operator lookup.
    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } op_hit_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // One-character operators.
    function automatic op_hit_t op_lookup(input logic [7:0] c);
        op_hit_t o;
        o.hit  = 1'b1;
        o.kind = KIND_UNKNOWN;
        case (c)
            8'h2B:   o.kind = KIND_PLUS;
            8'h2D:   o.kind = KIND_MINUS;
            8'h2A:   o.kind = KIND_STAR;
            8'h2F:   o.kind = KIND_SLASH;
            8'h3D:   o.kind = KIND_EQUAL;
            8'h3A:   o.kind = KIND_COLON;
            8'h3B:   o.kind = KIND_SEMI;
            8'h2C:   o.kind = KIND_COMMA;
            8'h28:   o.kind = KIND_LPAREN;
            8'h29:   o.kind = KIND_RPAREN;
            8'h7B:   o.kind = KIND_LBRACE;
            8'h7D:   o.kind = KIND_RBRACE;
            default: o.hit  = 1'b0;
        endcase
        return o;
    endfunction

    // Kind of a finished word from its collected prefix.
    function automatic logic [4:0] word_kind(input logic [55:0] w);
        logic [4:0] k;
        k = KIND_IDENT;
        if (w == WORD_INT)          k = KIND_KW_INT;
        else if (w == WORD_BOOL)    k = KIND_KW_BOOL;
        else if (w == WORD_DSPL)    k = KIND_KW_DSPL;
        else if (w == WORD_STRING)  k = KIND_KW_STRING;
        else if (w == WORD_DECIMAL) k = KIND_KW_DECIMAL;
        else if (w == WORD_TRUE)    k = KIND_BOOLEAN;
        else if (w == WORD_FALSE)   k = KIND_BOOLEAN;
        return k;
    endfunction

endpackage

// ----- hw/rtl/stt_if.sv -----
// ============================================================================
// Tokenizer channels
// Valid/ready channels for text bytes in and tokens out.
// ============================================================================

// Text bytes into the tokenizer.
interface stt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Tokens out of the tokenizer.
interface stt_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic        run_last;

    modport source (output valid, output token_kind, output start_offset,
                    output lexeme_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input lexeme_length, input run_last, output ready);
endinterface

// ----- hw/rtl/stt_scan.sv -----
// ============================================================================
// Tokenizer scanner
// Input register, lexer state and the per-byte scan step that yields up to
// two tokens for the result queue.
// ============================================================================
module stt_scan #(
    parameter int unsigned POSITION_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    stt_text_if.sink          text,
    input  logic              room,
    output stt_pkg::stt_push_t push
);
    import stt_pkg::*;

    localparam int unsigned PW = POSITION_WIDTH;
    localparam logic [PW-1:0] POS_MAX = '1;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_COMMENT = 3'd1;
    localparam logic [2:0] MODE_MINUS   = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_WORD    = 3'd4;
    localparam logic [2:0] MODE_STRING  = 3'd5;

    typedef struct packed {
        logic     v;
        stt_res_t r;
    } emit_t;

    // Held input item.
    logic        hold_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;

    // Lexer state.
    logic [2:0]    mode_reg,   mode_next;
    logic [PW-1:0] start_reg,  start_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [55:0]   prefix_reg, prefix_next;
    logic [1:0]    flags_reg,  flags_next;

    logic    fire;
    logic    do_fresh;
    emit_t   ea;
    emit_t   eb;
    emit_t   ec;
    op_hit_t op;
    logic [PW-1:0] pos_inc;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    function automatic logic [15:0] sat16(input logic [PW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic emit_t make_emit(input logic [4:0] kind,
                                        input logic [PW-1:0] s,
                                        input logic [PW-1:0] e);
        emit_t         x;
        logic [PW-1:0] len;
        len                = (e > s) ? e - s : '0;
        x.v                = 1'b1;
        x.r.token_kind     = kind;
        x.r.start_offset   = sat16(s);
        x.r.lexeme_length  = sat16(len);
        x.r.run_last       = 1'b0;
        return x;
    endfunction

    // A held item is scanned once the queue has room for two results.
    assign fire       = hold_valid_reg && room;
    assign text.ready = !hold_valid_reg || room;
    assign pos_inc    = sat_inc(pos_reg);
    assign op         = op_lookup(byte_reg);

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (text.valid && text.ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            byte_reg <= text.text_byte;
            eot_reg  <= text.end_of_text;
        end
    end

    // Scan step: continue the open token, then start afresh where it ends,
    // then flush whatever is open at the end of the text.
    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        prefix_next = prefix_reg;
        flags_next  = flags_reg;
        do_fresh    = 1'b0;
        ea          = '0;
        eb          = '0;
        ec          = '0;

        case (mode_reg)
            MODE_COMMENT:
            begin
                if (byte_reg == CH_NEWLINE)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_MINUS:
            begin
                if (is_digit(byte_reg))
                begin
                    mode_next  = MODE_NUMBER;
                    flags_next = 2'b00;
                end
                else
                begin
                    ea       = make_emit(KIND_MINUS, start_reg, sat_inc(start_reg));
                    do_fresh = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(byte_reg))
                begin
                    if (flags_reg[0] && (byte_reg != CH_ZERO))
                    begin
                        flags_next[1] = 1'b1;
                    end
                end
                else if ((byte_reg == CH_DOT) && !flags_reg[0])
                begin
                    flags_next[0] = 1'b1;
                end
                else
                begin
                    ea = make_emit((flags_reg == 2'b11) ? KIND_DECIMAL : KIND_INTEGER,
                                   start_reg, pos_reg);
                    do_fresh = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_word(byte_reg))
                begin
                    // Words longer than seven bytes saturate to all ones.
                    if (prefix_reg[55:48] != 8'h00)
                    begin
                        prefix_next = '1;
                    end
                    else
                    begin
                        prefix_next = {prefix_reg[47:0], byte_reg};
                    end
                end
                else
                begin
                    ea       = make_emit(word_kind(prefix_reg), start_reg, pos_reg);
                    do_fresh = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (byte_reg == CH_QUOTE)
                begin
                    ea        = make_emit(KIND_STRING, start_reg, pos_reg);
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // Classify the byte as the first of a new token.
        if (do_fresh)
        begin
            mode_next = MODE_IDLE;
            if (is_space(byte_reg))
            begin
                mode_next = MODE_IDLE;
            end
            else if (byte_reg == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (byte_reg == CH_DASH)
            begin
                mode_next  = MODE_MINUS;
                start_next = pos_reg;
            end
            else if (is_digit(byte_reg))
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                flags_next = 2'b00;
            end
            else if (is_alpha(byte_reg) || (byte_reg == CH_USCORE))
            begin
                mode_next   = MODE_WORD;
                start_next  = pos_reg;
                prefix_next = {48'h0, byte_reg};
            end
            else if (byte_reg == CH_QUOTE)
            begin
                mode_next  = MODE_STRING;
                start_next = pos_inc;
            end
            else if (op.hit)
            begin
                eb = make_emit(op.kind, pos_reg, pos_inc);
            end
            else
            begin
                eb = make_emit(KIND_UNKNOWN, pos_reg, pos_inc);
            end
        end

        // End of text: close the open token and return to the reset state.
        if (eot_reg)
        begin
            case (mode_next)
                MODE_MINUS:  ec = make_emit(KIND_MINUS, start_next, sat_inc(start_next));
                MODE_NUMBER: ec = make_emit((flags_next == 2'b11) ? KIND_DECIMAL
                                                                  : KIND_INTEGER,
                                            start_next, pos_inc);
                MODE_WORD:   ec = make_emit(word_kind(prefix_next), start_next, pos_inc);
                MODE_STRING: ec = make_emit(KIND_UNKNOWN, start_next, pos_inc);
                default:     ec = '0;
            endcase
            mode_next   = MODE_IDLE;
            start_next  = '0;
            pos_next    = '0;
            prefix_next = '0;
            flags_next  = 2'b00;
        end
        else
        begin
            pos_next = pos_inc;
        end
    end

    // Pack the results in order; at most two are ever valid together.
    always_comb
    begin
        push       = '0;
        push.count = fire ? (2'({1'b0, ea.v}) + 2'({1'b0, eb.v}) + 2'({1'b0, ec.v}))
                          : 2'd0;
        push.res0  = ea.v ? ea.r : (eb.v ? eb.r : ec.r);
        push.res1  = (ea.v && eb.v) ? eb.r : ec.r;
        push.res0.run_last = (push.count == 2'd1);
        push.res1.run_last = 1'b1;
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            pos_reg    <= '0;
            prefix_reg <= '0;
            flags_reg  <= 2'b00;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
            flags_reg  <= flags_next;
        end
    end

endmodule

// ----- hw/rtl/stt_out_queue.sv -----
// ============================================================================
// Tokenizer result queue
// Short shifting queue that takes up to two tokens a cycle and delivers one while the receiver is ready.
// ============================================================================
module stt_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  stt_pkg::stt_push_t push,
    output logic               room,
    stt_token_if.source        tokens
);
    import stt_pkg::*;

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    stt_res_t        slot_reg [QUEUE_DEPTH];
    stt_res_t        slot_next [QUEUE_DEPTH];
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   kept;
    logic            pop;

    assign pop  = tokens.valid && tokens.ready;
    assign room = (cnt_reg <= CW'(QUEUE_DEPTH - 2));
    assign kept = cnt_reg - CW'(pop);

    // Head of the queue drives the channel.
    assign tokens.valid         = (cnt_reg != '0);
    assign tokens.token_kind    = slot_reg[0].token_kind;
    assign tokens.start_offset  = slot_reg[0].start_offset;
    assign tokens.lexeme_length = slot_reg[0].lexeme_length;
    assign tokens.run_last      = slot_reg[0].run_last;

    // Shift out the delivered item, then append the new results behind the rest.
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
            begin
                slot_next[i] = slot_reg[(i + 1) % QUEUE_DEPTH];
            end
            else
            begin
                slot_next[i] = slot_reg[i];
            end
            if ((push.count != 2'd0) && (CW'(i) == kept))
            begin
                slot_next[i] = push.res0;
            end
            if ((push.count == 2'd2) && (CW'(i) == kept + 1'b1))
            begin
                slot_next[i] = push.res1;
            end
        end
        cnt_next = kept + CW'(push.count);
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Queue slots.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

// ----- hw/rtl/source_text_tokenizer_unit.sv -----
// ============================================================================
// Source text tokenizer
// Streaming lexer: bytes of source text in, tokens with kind, start offset
// and length out.
// ============================================================================
//
//  Channel  | Role   | Payload                                          | Handshake
//  ---------+--------+--------------------------------------------------+----------
//  text     | sink   | text_byte[7:0], end_of_text                      | valid/ready
//  tokens   | source | token_kind[4:0], start_offset[15:0],             | valid/ready
//           |        | lexeme_length[15:0], run_last                    |
//
//  One byte is accepted per cycle while the result queue has room; the scan step
//  for a byte is combinational, between the input register and the result queue.
//  A token is registered in the result queue once its byte is scanned, and is
//  offered on the token channel when it reaches the head of the queue.
//  The token channel delivers one item per cycle while ready is high; a held
//  byte waits while three or more tokens are queued, and input stalls while it
//  waits. Reset returns the scanner to the start of a text at position 0.
//
module source_text_tokenizer_unit #(
    parameter int unsigned POSITION_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    stt_text_if.sink     text,
    stt_token_if.source  tokens
);
    import stt_pkg::*;

    stt_push_t push;
    logic      room;

    // Scanner with its input register and lexer state.
    stt_scan #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .room  (room),
        .push  (push)
    );

    // Result queue in front of the token channel.
    stt_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .tokens (tokens)
    );

endmodule

// ----- hw/rtl/stt_checker.sv -----
// ============================================================================
// Tokenizer checker
// Port-level assertions on the token channel, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module stt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [4:0]  tok_kind,
    input logic [15:0] tok_start,
    input logic [15:0] tok_length,
    input logic        tok_last
);
    import stt_pkg::*;

    // A waiting token stays offered.
    `STT_ASSERT(a_tok_hold, tok_valid && !tok_ready |=> tok_valid, "token withdrawn while stalled")

    // A waiting token keeps its payload.
    `STT_ASSERT(a_tok_stable, tok_valid && !tok_ready |=> $stable({tok_kind, tok_start, tok_length, tok_last}), "token changed while stalled")

    // Only defined kinds leave the block.
    `STT_ASSERT(a_kind_range, tok_valid |-> tok_kind <= KIND_UNKNOWN, "token kind out of range")

    // Nothing is offered while reset is held.
    `STT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !tok_valid, "token offered during reset")

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (tokens.valid),
    .tok_ready  (tokens.ready),
    .tok_kind   (tokens.token_kind),
    .tok_start  (tokens.start_offset),
    .tok_length (tokens.lexeme_length),
    .tok_last   (tokens.run_last)
);

// ----- tb/sv/source_text_tokenizer_unit_test.sv -----
// ============================================================================
// Tokenizer unit test
// Feeds texts byte by byte through the tokenizer, predicts every token from
// its own scanner model and checks each delivered token field by field.
// Directed texts cover keywords, booleans, operators, number forms, strings,
// comments and odd bytes; random texts follow under varying idling on both
// channels.
// ============================================================================
module source_text_tokenizer_unit_test;

    import stt_pkg::*;

    localparam int POS_WIDTH   = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_LIVE = 90;

    // Scanner modes of the predictor.
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_MINUS,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_STRING
    } scan_mode_e;

    logic clk;
    logic rst_n;

    stt_text_if  text_ch ();
    stt_token_if tok_ch ();

    source_text_tokenizer_unit #(
        .POSITION_WIDTH (POS_WIDTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    // Predictor state.
    scan_mode_e  lex_mode;
    logic [15:0] lex_start;
    logic [15:0] lex_pos;
    logic [55:0] lex_word;
    logic        lex_dot;
    logic        lex_frac;

    stt_res_t step_out[$];
    stt_res_t expected_tokens[$];

    // Stimulus state.
    logic [7:0] text_buf[$];
    int         live_bytes;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_left;
    int         mismatches;

    string op_set  = "+-*/=:;,(){}";
    string alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string kw_list[10] = '{"int", "bool", "dspl", "string", "decimal",
                           "true", "false", "tru", "falsely", "decimals"};

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return alpha_char(c) || digit_char(c) || c == CH_USCORE;
    endfunction

    function automatic logic blank_char(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [15:0] pos_next(input logic [15:0] p);
        return (p == {POS_WIDTH{1'b1}}) ? p : p + 16'd1;
    endfunction

    function automatic logic [4:0] number_token_kind();
        return (lex_dot && lex_frac) ? KIND_DECIMAL : KIND_INTEGER;
    endfunction

    function automatic logic [4:0] word_token_kind();
        case (lex_word)
            WORD_INT:     return KIND_KW_INT;
            WORD_BOOL:    return KIND_KW_BOOL;
            WORD_DSPL:    return KIND_KW_DSPL;
            WORD_STRING:  return KIND_KW_STRING;
            WORD_DECIMAL: return KIND_KW_DECIMAL;
            WORD_TRUE:    return KIND_BOOLEAN;
            WORD_FALSE:   return KIND_BOOLEAN;
            default:      return KIND_IDENT;
        endcase
    endfunction

    // Queues one token of this byte; a byte never yields more than two.
    function automatic void add_token(input logic [4:0] kind, input logic [15:0] first,
                                      input logic [15:0] stop);
        stt_res_t t;
        t.token_kind    = kind;
        t.start_offset  = first;
        t.lexeme_length = (stop > first) ? stop - first : 16'd0;
        t.run_last      = 1'b0;
        if (step_out.size() < 2)
            step_out.push_back(t);
    endfunction

    function automatic void clear_scanner();
        lex_mode  = SCAN_IDLE;
        lex_start = '0;
        lex_pos   = '0;
        lex_word  = '0;
        lex_dot   = 1'b0;
        lex_frac  = 1'b0;
    endfunction

    // A byte seen between tokens either opens one or stands as a token itself.
    function automatic void open_token(input logic [7:0] c, input logic [15:0] p);
        int hit;
        hit      = -1;
        lex_mode = SCAN_IDLE;
        if (blank_char(c))
            return;
        if (c == CH_HASH)
        begin
            lex_mode = SCAN_COMMENT;
        end
        else if (c == CH_DASH)
        begin
            lex_mode  = SCAN_MINUS;
            lex_start = p;
        end
        else if (digit_char(c))
        begin
            lex_mode  = SCAN_NUMBER;
            lex_start = p;
            lex_dot   = 1'b0;
            lex_frac  = 1'b0;
        end
        else if (alpha_char(c) || c == CH_USCORE)
        begin
            lex_mode  = SCAN_WORD;
            lex_start = p;
            lex_word  = {48'd0, c};
        end
        else if (c == CH_QUOTE)
        begin
            lex_mode  = SCAN_STRING;
            lex_start = pos_next(p);
        end
        else
        begin
            for (int i = 0; i < op_set.len(); i++)
                if (op_set[i] == c)
                    hit = i;
            if (hit >= 0)
                add_token(KIND_PLUS + 5'(hit), p, pos_next(p));
            else
                add_token(KIND_UNKNOWN, p, pos_next(p));
        end
    endfunction

    // Works out the tokens that one accepted byte causes.
    function automatic void predict_tokens(input logic [7:0] c, input logic eot);
        logic [15:0] p;
        logic [15:0] nxt;
        p   = lex_pos;
        nxt = pos_next(p);
        step_out.delete();

        case (lex_mode)
            SCAN_COMMENT:
            begin
                if (c == CH_NEWLINE)
                    lex_mode = SCAN_IDLE;
            end
            SCAN_MINUS:
            begin
                if (digit_char(c))
                begin
                    lex_mode = SCAN_NUMBER;
                    lex_dot  = 1'b0;
                    lex_frac = 1'b0;
                end
                else
                begin
                    add_token(KIND_MINUS, lex_start, pos_next(lex_start));
                    open_token(c, p);
                end
            end
            SCAN_NUMBER:
            begin
                if (digit_char(c))
                begin
                    if (lex_dot && c != CH_ZERO)
                        lex_frac = 1'b1;
                end
                else if (c == CH_DOT && !lex_dot)
                begin
                    lex_dot = 1'b1;
                end
                else
                begin
                    add_token(number_token_kind(), lex_start, p);
                    open_token(c, p);
                end
            end
            SCAN_WORD:
            begin
                if (word_char(c))
                begin
                    // Words longer than seven bytes can never be reserved.
                    if (lex_word[55:48] != 8'd0)
                        lex_word = '1;
                    else
                        lex_word = {lex_word[47:0], c};
                end
                else
                begin
                    add_token(word_token_kind(), lex_start, p);
                    open_token(c, p);
                end
            end
            SCAN_STRING:
            begin
                if (c == CH_QUOTE)
                begin
                    add_token(KIND_STRING, lex_start, p);
                    lex_mode = SCAN_IDLE;
                end
            end
            default: open_token(c, p);
        endcase

        // The last byte of a text closes whatever is open.
        if (eot)
        begin
            case (lex_mode)
                SCAN_MINUS:  add_token(KIND_MINUS, lex_start, pos_next(lex_start));
                SCAN_NUMBER: add_token(number_token_kind(), lex_start, nxt);
                SCAN_WORD:   add_token(word_token_kind(), lex_start, nxt);
                SCAN_STRING: add_token(KIND_UNKNOWN, lex_start, nxt);
                default: ;
            endcase
            clear_scanner();
        end
        else
        begin
            lex_pos = nxt;
        end

        if (step_out.size() > 0)
            step_out[step_out.size() - 1].run_last = 1'b1;
        foreach (step_out[i])
            expected_tokens.push_back(step_out[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Clock, token receiver, checker and watchdog
    // ------------------------------------------------------------------------

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Token ready, with an occasional long hold-off counted down here.
    initial
    begin : token_receiver
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                tok_ch.ready <= 1'b0;
            end
            else
            begin
                tok_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Each delivered token is matched against the oldest prediction.
    initial
    begin : token_checker
        stt_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && tok_ch.valid && tok_ch.ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           tok_ch.token_kind, tok_ch.start_offset, tok_ch.lexeme_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (tok_ch.token_kind !== want.token_kind)
                    begin
                        $error("token_kind: expected %0d, got %0d",
                               want.token_kind, tok_ch.token_kind);
                        mismatches++;
                    end
                    if (tok_ch.start_offset !== want.start_offset)
                    begin
                        $error("start_offset: expected %0d, got %0d",
                               want.start_offset, tok_ch.start_offset);
                        mismatches++;
                    end
                    if (tok_ch.lexeme_length !== want.lexeme_length)
                    begin
                        $error("lexeme_length: expected %0d, got %0d",
                               want.lexeme_length, tok_ch.lexeme_length);
                        mismatches++;
                    end
                    if (tok_ch.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %0d, got %0d",
                               want.run_last, tok_ch.run_last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------------

    // Offers one byte from a falling edge and returns at the falling edge
    // after it has been taken.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= c;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        predict_tokens(c, eot);
        @(negedge clk);
    endtask

    task automatic put(input logic [7:0] c, input bit live);
        text_buf.push_back(c);
        if (live)
            live_bytes++;
    endtask

    task automatic put_str(input string s, input bit live);
        for (int i = 0; i < s.len(); i++)
            put(s[i], live);
    endtask

    // Sends the buffered bytes as one text, the last one closing it.
    task automatic send_buf();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_text(input string s);
        put_str(s, 1'b1);
        send_buf();
    endtask

    // Stops offering and waits until every predicted token has arrived.
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random text pieces
    // ------------------------------------------------------------------------

    task automatic put_ident();
        int n;
        n = $urandom_range(1, 10);
        if ($urandom_range(2) == 0)
            put_str(kw_list[$urandom_range(9)], 1'b1);
        else
            put(alnum[$urandom_range(52)], 1'b1);
        repeat (n - 1) put(alnum[$urandom_range(62)], 1'b1);
    endtask

    task automatic put_digits(input int lo, input int hi, input bit zero_heavy);
        repeat ($urandom_range(lo, hi))
        begin
            if (zero_heavy && $urandom_range(1) == 0)
                put(CH_ZERO, 1'b1);
            else
                put(CH_ZERO + 8'($urandom_range(9)), 1'b1);
        end
    endtask

    task automatic put_number();
        if ($urandom_range(2) == 0)
            put(CH_DASH, 1'b1);
        put_digits(1, 4, 1'b0);
        if ($urandom_range(1) == 0)
        begin
            put(CH_DOT, 1'b1);
            put_digits(0, 3, 1'b1);
            if ($urandom_range(5) == 0)
            begin
                put(CH_DOT, 1'b1);
                put_digits(0, 2, 1'b0);
            end
        end
    endtask

    task automatic put_string_lit();
        logic [7:0] c;
        put(CH_QUOTE, 1'b1);
        repeat ($urandom_range(0, 6))
        begin
            c = 8'($urandom_range(255));
            if (c == CH_QUOTE)
                c = CH_SPACE;
            put(c, 1'b1);
        end
        if ($urandom_range(9) != 0)
            put(CH_QUOTE, 1'b1);
    endtask

    task automatic put_comment();
        logic [7:0] c;
        put(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 8))
        begin
            c = 8'($urandom_range(255));
            if (c == CH_NEWLINE)
                c = CH_SPACE;
            put(c, 1'b0);
        end
        if ($urandom_range(4) != 0)
            put(CH_NEWLINE, 1'b0);
    endtask

    task automatic put_blank();
        int k;
        k = $urandom_range(8, 13);
        put((k == 8) ? CH_SPACE : 8'(k), 1'b0);
    endtask

    // Mostly well-formed token sequences, with some noise bytes.
    task automatic build_random_text();
        repeat ($urandom_range(2, 12))
        begin
            case ($urandom_range(9))
                0:       put_str(kw_list[$urandom_range(9)], 1'b1);
                1, 2:    put_ident();
                3, 4:    put_number();
                5:       put_string_lit();
                6:       put_comment();
                7:       put(op_set[$urandom_range(11)], 1'b1);
                default: put(8'($urandom_range(255)), 1'b1);
            endcase
            if ($urandom_range(3) != 0)
                put_blank();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_keywords();
        send_text("int bool dspl string decimal");
    endtask

    // True and false only as whole words.
    task automatic test_booleans();
        send_text("true false fals truer _x9");
    endtask

    // Every operator, with the minus followed by a non-digit.
    task automatic test_operators();
        send_text("+-*/=:;,(){}");
    endtask

    // Negative numbers, lone minus, zero fractions, trailing and second dots.
    task automatic test_numbers();
        send_text("-5 -x 1.50 1.0 2. 3.4.5 --7");
        send_text("-");
    endtask

    // Closed and unterminated strings, comments closed by newline and by the end.
    task automatic test_strings_comments();
        send_text("\"ab\"#c\n\"xy");
        send_text("\"");
        send_text("a# x");
    endtask

    // Zero byte and top-bit bytes are unknown tokens.
    task automatic test_odd_bytes();
        put(8'h00, 1'b1);
        put(8'hFF, 1'b1);
        put(8'h80, 1'b1);
        put("z", 1'b1);
        send_buf();
    endtask

    // The receiver holds off while operators keep coming, so input stalls.
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (40) put(op_set[$urandom_range(11)], 1'b1);
        send_buf();
        wait_drained();
    endtask

    task automatic test_random_texts(input int target);
        live_bytes = 0;
        while (live_bytes < target)
        begin
            build_random_text();
            send_buf();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin : main
        rst_n               = 1'b0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = 8'd0;
        text_ch.end_of_text = 1'b0;
        tok_ch.ready        = 1'b0;
        hold_left           = 0;
        mismatches          = 0;
        send_idle_pct       = 23;
        recv_idle_pct       = 63;
        clear_scanner();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_keywords();
        test_booleans();
        test_operators();
        test_numbers();
        test_strings_comments();
        test_odd_bytes();
        test_random_texts(RANDOM_LIVE);

        send_idle_pct = 63;
        recv_idle_pct = 23;
        test_backpressure();
        test_random_texts(RANDOM_LIVE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_texts(RANDOM_LIVE);

        wait_drained();
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
